// ===== design/sfqd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfqd_pkg
// Shared constants, codes and item types of the SFQ(D) dispatch queue.
// ----------------------------------------------------------------------------
package sfqd_pkg;

  localparam int APP_COUNT   = 8;
  localparam int QUEUE_SLOTS = 64;

  localparam int APP_W    = 3;
  localparam int HANDLE_W = 16;
  localparam int TAG_W    = 32;
  localparam int DEPTH_W  = 7;
  localparam int SLOT_W   = $clog2(QUEUE_SLOTS);
  localparam int CNT_W    = $clog2(QUEUE_SLOTS + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [APP_W-1:0]    app;
    logic [HANDLE_W-1:0] request_handle;
  } sfqd_in_t;

  typedef struct packed {
    logic                granted;
    logic                overflow;
    logic                found;
    logic [APP_W-1:0]    out_app;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    out_start_tag;
    logic [TAG_W-1:0]    out_finish_tag;
    logic                idle;
  } sfqd_out_t;

  // one queued request
  typedef struct packed {
    logic [APP_W-1:0]    app;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    start;
  } slot_t;

  // per-application table entry
  typedef struct packed {
    logic [TAG_W-1:0] last_finish;
    logic [CNT_W-1:0] pending;
  } app_ent_t;

  typedef struct packed {
    logic push;
    logic rd;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } fifo_sts_t;

endpackage
`default_nettype wire

// ===== design/sfq_depth_dispatch_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_depth_dispatch_queue_unit
// Start-time fair queueing dispatch queue with an outstanding-request limit.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a rising
//   edge with start high and busy low. opcode OP_ENQ queues a request for
//   cmd.app, OP_DEQ pops the oldest one (or, on an empty queue, returns one
//   in-flight slot). An enqueue to a full queue is dropped with overflow set.
//   Result channel: done pulses for one cycle with result valid. The
//   receiver has no back-pressure; each item gives exactly one result.
//   Config: cfg_we/cfg_wdata write dispatch_depth (reset 1); the user writes it only while idle (not enforced).
// Timing:
//   Enqueue: the accept edge reads the app table; in ST_ENQ the result is
//   registered and busy drops with it, so the next item can then be taken.
//   Dequeue: the accept edge reads the FIFO head; ST_DEQ registers the result
//   and reads the popped app's table entry; ST_DEQ_WB then writes back the
//   pending count. The app table read-modify-write sets the rate.
//   A dequeue on an empty queue finishes in ST_DEQ, with no write-back.
// Reset:
//   Synchronous rst clears the FIFO pointers, virtual time, in-flight count,
//   the app table valid bits (entries then read as zero) and depth to 1.
// ----------------------------------------------------------------------------
module sfq_depth_dispatch_queue_unit
  import sfqd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire sfqd_in_t           cmd,
  output      logic               busy,
  input  wire logic               cfg_we,
  input  wire logic [DEPTH_W-1:0] cfg_wdata,
  output      logic               done,
  output      sfqd_out_t          result
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ENQ    = 2'd1;
  localparam logic [1:0] ST_DEQ    = 2'd2;
  localparam logic [1:0] ST_DEQ_WB = 2'd3;

  logic [1:0]         state, state_next;
  logic [DEPTH_W-1:0] depth;
  logic [TAG_W-1:0]   vtime, vtime_next;
  logic [CNT_W-1:0]   in_flight, in_flight_next;

  // latched item payload
  logic [APP_W-1:0]    op_app;
  logic [HANDLE_W-1:0] op_handle;
  logic [APP_W-1:0]    deq_app;

  // per-app table: last finish tag and pending count, valid bits for reset
  app_ent_t             app_mem [APP_COUNT];
  logic [APP_COUNT-1:0] app_vld;
  app_ent_t            tbl_q;
  logic                tbl_vld_q;
  app_ent_t            tbl_ent;
  logic                tbl_rd_en;
  logic [APP_W-1:0]    tbl_rd_addr;
  logic                tbl_we;
  logic [APP_W-1:0]    tbl_wr_addr;
  app_ent_t            tbl_wr_data;

  fifo_ctl_t fctl;
  fifo_sts_t fsts;
  slot_t     f_wr;
  slot_t     f_rd;

  logic      accept;
  logic      done_next;
  sfqd_out_t res_next;
  logic [TAG_W-1:0] enq_start;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  sfqd_req_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fctl),
    .wr_data (f_wr),
    .rd_data (f_rd),
    .sts     (fsts)
  );

  // --- app table memory -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (tbl_rd_en) begin
      tbl_q     <= app_mem[tbl_rd_addr];
      tbl_vld_q <= app_vld[tbl_rd_addr];
    end
    if (tbl_we) begin
      app_mem[tbl_wr_addr] <= tbl_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      app_vld <= '0;
    end else if (tbl_we) begin
      app_vld[tbl_wr_addr] <= 1'b1;
    end
  end

  // never-written entries read as zero
  assign tbl_ent = tbl_vld_q ? tbl_q : '0;

  // larger of virtual time and the app's last finish tag
  assign enq_start = (vtime > tbl_ent.last_finish) ? vtime : tbl_ent.last_finish;

  // --- control --------------------------------------------------------------
  always_comb begin
    state_next     = state;
    vtime_next     = vtime;
    in_flight_next = in_flight;
    fctl           = '0;
    f_wr.app       = op_app;
    f_wr.handle    = op_handle;
    f_wr.start     = enq_start;
    tbl_rd_en      = 1'b0;
    tbl_rd_addr    = cmd.app;
    tbl_we         = 1'b0;
    tbl_wr_addr    = op_app;
    tbl_wr_data    = tbl_ent;
    done_next      = 1'b0;
    res_next       = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_ENQ) begin
            tbl_rd_en  = 1'b1;
            state_next = ST_ENQ;
          end else begin
            fctl.rd    = 1'b1;
            state_next = ST_DEQ;
          end
        end
      end
      ST_ENQ: begin
        done_next           = 1'b1;
        res_next.out_app    = op_app;
        res_next.out_handle = op_handle;
        state_next          = ST_IDLE;
        if (fsts.full) begin
          res_next.overflow = 1'b1;
        end else begin
          fctl.push                   = 1'b1;
          tbl_we                      = 1'b1;
          tbl_wr_data.last_finish     = enq_start + TAG_W'(1);
          tbl_wr_data.pending         = tbl_ent.pending + CNT_W'(1);
          res_next.out_start_tag      = enq_start;
          res_next.out_finish_tag     = enq_start + TAG_W'(1);
          if (in_flight < CNT_W'(depth)) begin
            res_next.granted = 1'b1;
            in_flight_next   = in_flight + CNT_W'(1);
          end
        end
        res_next.idle = 1'b0;
      end
      ST_DEQ: begin
        done_next = 1'b1;
        if (fsts.empty) begin
          res_next.idle = 1'b1;
          if (in_flight != '0) begin
            in_flight_next = in_flight - CNT_W'(1);
          end
          state_next = ST_IDLE;
        end else begin
          fctl.pop               = 1'b1;
          vtime_next             = f_rd.start;
          res_next.found         = 1'b1;
          res_next.out_app       = f_rd.app;
          res_next.out_handle    = f_rd.handle;
          res_next.out_start_tag = f_rd.start;
          res_next.idle          = (fsts.count == CNT_W'(1));
          tbl_rd_en              = 1'b1;
          tbl_rd_addr            = f_rd.app;
          state_next             = ST_DEQ_WB;
        end
      end
      ST_DEQ_WB: begin
        // pending count of popped app, saturating at zero
        tbl_wr_addr         = deq_app;
        tbl_wr_data.pending = tbl_ent.pending - CNT_W'(1);
        tbl_we              = (tbl_ent.pending != '0);
        state_next          = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --- registers ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vtime     <= '0;
      in_flight <= '0;
      depth     <= DEPTH_W'(1);
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      vtime     <= vtime_next;
      in_flight <= in_flight_next;
      done      <= done_next;
      if (cfg_we) begin
        depth <= cfg_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_app    <= cmd.app;
      op_handle <= cmd.request_handle;
    end
    if (state == ST_DEQ) begin
      deq_app <= f_rd.app;
    end
    result <= res_next;
  end

endmodule
`default_nettype wire

// ===== design/sfqd_req_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfqd_req_fifo
// Request FIFO: slot memory with registered head read, head/tail/count.
// ----------------------------------------------------------------------------
module sfqd_req_fifo
  import sfqd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fifo_ctl_t ctl,
  input  wire slot_t     wr_data,
  output      slot_t     rd_data,
  output      fifo_sts_t sts
);

  slot_t             mem [QUEUE_SLOTS];
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail <= next_slot(tail);
      end
      if (ctl.pop) begin
        head <= next_slot(head);
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign sts.count = count;
  assign sts.empty = (count == '0);
  assign sts.full  = (count == CNT_W'(QUEUE_SLOTS));

endmodule
`default_nettype wire

// ===== design/sfqd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfqd_checker
// Port-level checks of the dispatch queue, bound to the top level.
// ----------------------------------------------------------------------------
module sfqd_checker
  import sfqd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire sfqd_out_t result
);

  // a taken item blocks the port for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after accepted item");

  // each accepted item brings a result, but not at once
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done)
    else $error("result one cycle after accept");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result missing two cycles after accept");

  // dequeue results carry no enqueue flags
  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> !result.granted && !result.overflow)
    else $error("found with enqueue flags");

  // a dropped item is never granted and the queue is full, not empty
  a_overflow_excl: assert property (@(posedge clk) disable iff (rst)
    done && result.overflow |-> !result.granted && !result.idle)
    else $error("overflow with grant or idle");

endmodule

bind sfq_depth_dispatch_queue_unit sfqd_checker u_sfqd_checker (.*);
`default_nettype wire
